### design/wkt_pkg.sv
`default_nettype none
package wkt_pkg;
    localparam int BOARD_SIDE = 8;
    localparam int STORE_SIDE = 8;
    localparam int SQUARES = STORE_SIDE * STORE_SIDE;
    localparam int MOVE_COUNT = 8;
    localparam int FULL_TOUR = BOARD_SIDE * BOARD_SIDE;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [2:0] row;
        logic [2:0] col;
        logic [2:0] rotation;
    } cmd_t;

    typedef struct packed {
        logic       moved;
        logic [2:0] cur_row;
        logic [2:0] cur_col;
        logic [6:0] move_number;
        logic       tour_complete;
        logic       tour_closed;
        logic [6:0] square_value;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CAND,
        ST_ONWARD,
        ST_MOVE,
        ST_READ,
        ST_DONE
    } state_t;

    function automatic logic signed [2:0] step_dr(input logic [2:0] k);
        logic signed [2:0] v;
        case (k)
            3'd0, 3'd1: v = 3'sd1;
            3'd2, 3'd3: v = 3'sd2;
            3'd4, 3'd5: v = -3'sd1;
            default:    v = -3'sd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [2:0] step_dc(input logic [2:0] k);
        logic signed [2:0] v;
        case (k)
            3'd0, 3'd4: v = 3'sd2;
            3'd1, 3'd5: v = -3'sd2;
            3'd2, 3'd6: v = 3'sd1;
            default:    v = -3'sd1;
        endcase
        return v;
    endfunction

    // target of move k from (r,c), with on-board flag in the msb
    function automatic logic [6:0] hop(input logic [2:0] r, input logic [2:0] c,
                                       input logic [2:0] k);
        logic signed [4:0] nr;
        logic signed [4:0] nc;
        logic ok;
        nr = $signed({2'b00, r}) + 5'(step_dr(k));
        nc = $signed({2'b00, c}) + 5'(step_dc(k));
        ok = (nr >= 0) && (nr < BOARD_SIDE) && (nc >= 0) && (nc < BOARD_SIDE);
        return {ok, nr[2:0], nc[2:0]};
    endfunction
endpackage
`default_nettype wire

### design/wkt_front.sv
`default_nettype none
module wkt_front
    import wkt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire cmd_t       cmd_in,
    output cmd_t            cmd_out,
    output logic            cmd_valid,
    input  wire logic       cmd_take
);
    // two entry command queue
    cmd_t       q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign full = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out = q_reg[rp_reg];
    assign wr = push && !full;
    assign rd = cmd_take && cmd_valid;

    always_ff @(posedge clk) begin
        if (wr) begin
            q_reg[wp_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule
`default_nettype wire

### design/wkt_back.sv
`default_nettype none
module wkt_back
    import wkt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_take,
    output logic      empty,
    input  wire logic pop,
    output res_t      res
);
    logic [6:0]         board_reg [SQUARES];
    logic [SQUARES-1:0] vld_reg;

    state_t      state_reg, state_next;
    logic [2:0]  kr_reg, kc_reg, or_reg, oc_reg;
    logic [6:0]  visits_reg;
    cmd_t        cur_reg;
    logic [2:0]  t_reg, t_next;
    logic [2:0]  j_reg, j_next;
    logic [3:0]  deg_reg, deg_next;
    logic [3:0]  best_deg_reg, best_deg_next;
    logic [2:0]  best_reg, best_next;
    logic        found_reg, found_next;
    logic        wait_reg, wait_next;
    logic [6:0]  rd_data_reg;
    logic        rd_ok_reg;
    res_t        res_reg;
    logic        full_reg;

    logic [2:0]  k_cur;
    logic [6:0]  cand;
    logic [6:0]  onw;
    logic [6:0]  bt;
    logic [6:0]  addr_sq;
    logic        addr_ok;
    logic        sq_free;
    logic [6:0]  new_vis;
    logic [3:0]  deg_sum;
    logic        res_load;
    logic        adj;
    logic        complete;
    res_t        res_n;

    assign k_cur = cur_reg.rotation + t_reg;
    assign cand = hop(kr_reg, kc_reg, k_cur);
    assign onw = hop(cand[5:3], cand[2:0], j_reg);
    assign bt = hop(kr_reg, kc_reg, best_reg);
    assign new_vis = visits_reg + 7'd1;
    assign sq_free = rd_ok_reg && (rd_data_reg == 7'd0);
    assign deg_sum = deg_reg + 4'(sq_free);

    // board read address per phase
    always_comb
    begin
        addr_ok = 1'b0;
        addr_sq = 7'd0;
        case (state_reg)
            ST_CAND:
            begin
                addr_ok = cand[6];
                addr_sq = cand;
            end
            ST_ONWARD:
            begin
                addr_ok = onw[6];
                addr_sq = onw;
            end
            default:
            begin
                addr_ok = (cur_reg.row < BOARD_SIDE) && (cur_reg.col < BOARD_SIDE);
                addr_sq = {1'b0, cur_reg.row, cur_reg.col};
            end
        endcase
    end

    // board store: one registered read and at most one write per cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= vld_reg[addr_sq[5:0]] ? board_reg[addr_sq[5:0]] : 7'd0;
        rd_ok_reg <= addr_ok;
        if (state_reg == ST_CLEAR)
            board_reg[{cur_reg.row, cur_reg.col}] <= 7'd1;
        else if (state_reg == ST_MOVE && found_reg)
            board_reg[bt[5:0]] <= new_vis;
    end

    // written marks, so unwritten squares read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (state_reg == ST_CLEAR)
            vld_reg <= {{(SQUARES-1){1'b0}}, 1'b1} << {cur_reg.row, cur_reg.col};
        else if (state_reg == ST_MOVE && found_reg)
            vld_reg[bt[5:0]] <= 1'b1;
    end

    // sequencer: each board read has an issue step, flagged by wait_reg, and a use step
    always_comb
    begin
        state_next = state_reg;
        t_next = t_reg;
        j_next = j_reg;
        deg_next = deg_reg;
        best_deg_next = best_deg_reg;
        best_next = best_reg;
        found_next = found_reg;
        wait_next = wait_reg;
        cmd_take = 1'b0;
        res_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    found_next = 1'b0;
                    case (cmd.operation)
                        OP_START:
                            state_next = (cmd.row < BOARD_SIDE && cmd.col < BOARD_SIDE) ?
                                         ST_CLEAR : ST_DONE;
                        OP_STEP:
                        begin
                            if (visits_reg != 7'd0)
                            begin
                                state_next = ST_CAND;
                                t_next = 3'd0;
                                wait_next = 1'b1;
                                best_deg_next = 4'(MOVE_COUNT + 1);
                                best_next = 3'd0;
                            end
                            else
                                state_next = ST_DONE;
                        end
                        OP_READ: state_next = ST_READ;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: state_next = ST_DONE;
            ST_READ: state_next = ST_DONE;
            ST_CAND:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else if (sq_free)
                begin
                    state_next = ST_ONWARD;
                    j_next = 3'd0;
                    deg_next = 4'd0;
                    wait_next = 1'b1;
                end
                else if (t_reg == 3'd7)
                    state_next = ST_MOVE;
                else
                begin
                    t_next = t_reg + 3'd1;
                    wait_next = 1'b1;
                end
            end
            ST_ONWARD:
            begin
                if (wait_reg)
                    wait_next = 1'b0;
                else
                begin
                    deg_next = deg_sum;
                    wait_next = 1'b1;
                    if (j_reg == 3'd7)
                    begin
                        // strict compare keeps the first candidate on a tie
                        if (deg_sum < best_deg_reg)
                        begin
                            best_deg_next = deg_sum;
                            best_next = k_cur;
                            found_next = 1'b1;
                        end
                        if (t_reg == 3'd7)
                            state_next = ST_MOVE;
                        else
                        begin
                            state_next = ST_CAND;
                            t_next = t_reg + 3'd1;
                        end
                    end
                    else
                        j_next = j_reg + 3'd1;
                end
            end
            ST_MOVE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!full_reg || pop)
                begin
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg <= '0;
            kc_reg <= '0;
            or_reg <= '0;
            oc_reg <= '0;
            visits_reg <= '0;
            t_reg <= '0;
            j_reg <= '0;
            deg_reg <= '0;
            best_deg_reg <= '0;
            best_reg <= '0;
            found_reg <= 1'b0;
            wait_reg <= 1'b0;
            full_reg <= 1'b0;
            cur_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            t_reg <= t_next;
            j_reg <= j_next;
            deg_reg <= deg_next;
            best_deg_reg <= best_deg_next;
            best_reg <= best_next;
            found_reg <= found_next;
            wait_reg <= wait_next;
            if (cmd_take)
                cur_reg <= cmd;
            if (state_reg == ST_CLEAR)
            begin
                kr_reg <= cur_reg.row;
                kc_reg <= cur_reg.col;
                or_reg <= cur_reg.row;
                oc_reg <= cur_reg.col;
                visits_reg <= 7'd1;
            end
            else if (state_reg == ST_MOVE && found_reg)
            begin
                kr_reg <= bt[5:3];
                kc_reg <= bt[2:0];
                visits_reg <= new_vis;
            end
            if (res_load)
            begin
                res_reg <= res_n;
                full_reg <= 1'b1;
            end
            else if (pop && full_reg)
                full_reg <= 1'b0;
        end
    end

    // status word from the state after the item
    always_comb
    begin
        logic [6:0] h;
        adj = 1'b0;
        for (int k = 0; k < MOVE_COUNT; k++)
        begin
            h = hop(kr_reg, kc_reg, 3'(k));
            if (h[6] && h[5:3] == or_reg && h[2:0] == oc_reg)
                adj = 1'b1;
        end
        complete = (visits_reg == 7'(FULL_TOUR));
        res_n.moved = found_reg;
        res_n.cur_row = kr_reg;
        res_n.cur_col = kc_reg;
        res_n.move_number = visits_reg;
        res_n.tour_complete = complete;
        res_n.tour_closed = complete && adj;
        res_n.square_value = (cur_reg.operation == OP_READ && rd_ok_reg) ?
                             rd_data_reg : 7'd0;
    end

    assign empty = !full_reg;
    assign res = res_reg;
endmodule
`default_nettype wire

### design/warnsdorff_knight_tour_stepper.sv
// states from acceptance to the result word: nop, off-board start and step before any start
// go straight to ST_DONE; start passes ST_CLEAR and read passes ST_READ on the way;
// step reads all eight candidates and, for each unvisited one, its eight onward squares
// the back end handles one word at a time; its board reads, one at a time, set the step time
// a two-word command queue in front and a one-word result register let each side stall
// reset (rst_n low, asynchronous) empties both queues, clears knight state and board valid bits
`default_nettype none
module warnsdorff_knight_tour_stepper
    import wkt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] operation,
    input  wire logic [2:0] row,
    input  wire logic [2:0] col,
    input  wire logic [2:0] rotation,
    output logic            empty,
    input  wire logic       pop,
    output logic            moved,
    output logic [2:0]      cur_row,
    output logic [2:0]      cur_col,
    output logic [6:0]      move_number,
    output logic            tour_complete,
    output logic            tour_closed,
    output logic [6:0]      square_value
);
    cmd_t cmd_in;
    cmd_t cmd_q;
    logic cmd_valid;
    logic cmd_take;
    res_t res;

    // pack the incoming word
    assign cmd_in.operation = op_t'(operation);
    assign cmd_in.row = row;
    assign cmd_in.col = col;
    assign cmd_in.rotation = rotation;

    wkt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_out(cmd_q), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    // back end walks candidates and onward squares one board read at a time
    wkt_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_q), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res)
    );

    assign moved = res.moved;
    assign cur_row = res.cur_row;
    assign cur_col = res.cur_col;
    assign move_number = res.move_number;
    assign tour_complete = res.tour_complete;
    assign tour_closed = res.tour_closed;
    assign square_value = res.square_value;
endmodule
`default_nettype wire

### design/wkt_checker.sv
`default_nettype none
module wkt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       moved,
    input wire logic [6:0] move_number,
    input wire logic       tour_complete,
    input wire logic       tour_closed
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        empty == 1'b0 && !pop |=> empty == 1'b0 && $stable(move_number))
        else $error("result word changed while waiting");
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && tour_closed |-> tour_complete)
        else $error("closed without complete");
    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && tour_complete |-> move_number == 7'd64)
        else $error("complete with wrong count");
    a_moved: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && moved |-> move_number >= 7'd2)
        else $error("move without a started tour");
endmodule

bind warnsdorff_knight_tour_stepper wkt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .moved(moved),
    .move_number(move_number), .tour_complete(tour_complete), .tour_closed(tour_closed)
);
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wkt_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] operation;
    logic [2:0] row;
    logic [2:0] col;
    logic [2:0] rotation;
    logic       empty;
    logic       pop;
    logic       moved;
    logic [2:0] cur_row;
    logic [2:0] cur_col;
    logic [6:0] move_number;
    logic       tour_complete;
    logic       tour_closed;
    logic [6:0] square_value;

    warnsdorff_knight_tour_stepper u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .row(row), .col(col), .rotation(rotation),
        .empty(empty), .pop(pop), .moved(moved), .cur_row(cur_row),
        .cur_col(cur_col), .move_number(move_number),
        .tour_complete(tour_complete), .tour_closed(tour_closed),
        .square_value(square_value)
    );

    // board model of visit numbers, knight and origin squares
    logic [6:0] tour_board [SQUARES];
    logic [2:0] knight_r;
    logic [2:0] knight_c;
    logic [2:0] origin_r;
    logic [2:0] origin_c;
    logic [6:0] visit_count;

    res_t       expected_words [$];
    int         error_count;
    bit         hold_pop;

    // one row of the directed table; check_it marks a hand-typed result
    typedef struct {
        op_t        op;
        logic [2:0] r;
        logic [2:0] c;
        logic [2:0] rot;
        bit         check_it;
        res_t       want;
    } stim_row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    // generous limit: 758 items, each up to a full step, plus stalls
    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end

    function automatic bit square_free(input int r, input int c);
        if (r < 0 || r >= BOARD_SIDE || c < 0 || c >= BOARD_SIDE)
            return 1'b0;
        return tour_board[r * STORE_SIDE + c] == 7'd0;
    endfunction

    function automatic int move_dr(input int k);
        int dr [8] = '{1, 1, 2, 2, -1, -1, -2, -2};
        return dr[k];
    endfunction

    function automatic int move_dc(input int k);
        int dc [8] = '{2, -2, 1, -1, 2, -2, 1, -1};
        return dc[k];
    endfunction

    // apply one command to the board model and return the expected word
    function automatic res_t advance_tour(input op_t op, input logic [2:0] r,
                                          input logic [2:0] c, input logic [2:0] rot);
        res_t w;
        int   best;
        int   best_deg;
        int   k;
        int   nr;
        int   nc;
        int   deg;
        bit   adj;
        w = '0;
        case (op)
            OP_START:
            begin
                if (r < BOARD_SIDE && c < BOARD_SIDE)
                begin
                    foreach (tour_board[i])
                        tour_board[i] = 7'd0;
                    tour_board[r * STORE_SIDE + c] = 7'd1;
                    knight_r = r;
                    knight_c = c;
                    origin_r = r;
                    origin_c = c;
                    visit_count = 7'd1;
                end
            end
            OP_STEP:
            begin
                if (visit_count != 0)
                begin
                    best = -1;
                    best_deg = MOVE_COUNT + 1;
                    for (int t = 0; t < MOVE_COUNT; t++)
                    begin
                        k = (rot + t) % 8;
                        nr = knight_r + move_dr(k);
                        nc = knight_c + move_dc(k);
                        if (square_free(nr, nc))
                        begin
                            deg = 0;
                            for (int j = 0; j < MOVE_COUNT; j++)
                                if (square_free(nr + move_dr(j), nc + move_dc(j)))
                                    deg++;
                            if (deg < best_deg)
                            begin
                                best_deg = deg;
                                best = k;
                            end
                        end
                    end
                    if (best >= 0)
                    begin
                        nr = knight_r + move_dr(best);
                        nc = knight_c + move_dc(best);
                        visit_count = visit_count + 7'd1;
                        tour_board[nr * STORE_SIDE + nc] = visit_count;
                        knight_r = nr[2:0];
                        knight_c = nc[2:0];
                        w.moved = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (r < BOARD_SIDE && c < BOARD_SIDE)
                    w.square_value = tour_board[r * STORE_SIDE + c];
            end
            default: ;
        endcase
        adj = 1'b0;
        for (int j = 0; j < MOVE_COUNT; j++)
            if (knight_r + move_dr(j) == origin_r && knight_c + move_dc(j) == origin_c)
                adj = 1'b1;
        w.cur_row = knight_r;
        w.cur_col = knight_c;
        w.move_number = visit_count;
        w.tour_complete = (visit_count == FULL_TOUR);
        w.tour_closed = w.tour_complete && adj;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // hand one word to the block, with a random gap first; push stays high
    // after acceptance so back to back words need no second drive in one step
    task automatic send_word(input op_t op, input logic [2:0] r, input logic [2:0] c,
                             input logic [2:0] rot, input bit use_typed, input res_t typed);
        res_t w;
        int   gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        row <= r;
        col <= c;
        rotation <= rot;
        @(posedge clk);
        while (full)
            @(posedge clk);
        w = advance_tour(op, r, c, rot);
        expected_words.push_back(use_typed ? typed : w);
    endtask

    task automatic drain_all();
        push <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random pop gaps, and a long hold when asked
    initial
    begin
        res_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!empty && pop)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (moved !== want.moved)
                        report_mismatch("moved", moved, want.moved);
                    if (cur_row !== want.cur_row)
                        report_mismatch("cur_row", cur_row, want.cur_row);
                    if (cur_col !== want.cur_col)
                        report_mismatch("cur_col", cur_col, want.cur_col);
                    if (move_number !== want.move_number)
                        report_mismatch("move_number", move_number, want.move_number);
                    if (tour_complete !== want.tour_complete)
                        report_mismatch("tour_complete", tour_complete, want.tour_complete);
                    if (tour_closed !== want.tour_closed)
                        report_mismatch("tour_closed", tour_closed, want.tour_closed);
                    if (square_value !== want.square_value)
                        report_mismatch("square_value", square_value, want.square_value);
                end
            end
            if (hold_pop)
                pop <= 1'b0;
            else if ($urandom_range(0, 19) == 0)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(0, 3) != 0) || (error_count < 0);
        end
    end

    initial
    begin
        stim_row_t  directed [$];
        res_t       zero_word;
        res_t       w;
        op_t        op;
        int         pick;
        logic [2:0] rr;
        logic [2:0] cc;

        error_count = 0;
        hold_pop = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        operation = OP_NOP;
        row = 3'd0;
        col = 3'd0;
        rotation = 3'd0;
        foreach (tour_board[i])
            tour_board[i] = 7'd0;
        knight_r = 3'd0;
        knight_c = 3'd0;
        origin_r = 3'd0;
        origin_c = 3'd0;
        visit_count = 7'd0;
        zero_word = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: step does nothing, reads give zero, nop reports status
        directed.push_back('{OP_STEP, 3'd0, 3'd0, 3'd0, 1'b1, zero_word});
        directed.push_back('{OP_READ, 3'd7, 3'd7, 3'd0, 1'b1, zero_word});
        directed.push_back('{OP_NOP, 3'd7, 3'd7, 3'd7, 1'b1, zero_word});
        w = zero_word;
        w.cur_row = 3'd7;
        w.cur_col = 3'd7;
        w.move_number = 7'd1;
        directed.push_back('{OP_START, 3'd7, 3'd7, 3'd7, 1'b1, w});
        w.square_value = 7'd1;
        directed.push_back('{OP_READ, 3'd7, 3'd7, 3'd0, 1'b1, w});
        for (int i = 0; i < 8; i++)
            directed.push_back('{OP_STEP, 3'd0, 3'd0, 3'(i), 1'b0, zero_word});
        directed.push_back('{OP_READ, 3'd0, 3'd0, 3'd5, 1'b0, zero_word});
        directed.push_back('{OP_START, 3'd0, 3'd0, 3'd0, 1'b0, zero_word});
        directed.push_back('{OP_STEP, 3'd0, 3'd0, 3'd7, 1'b0, zero_word});
        directed.push_back('{OP_READ, 3'd3, 3'd4, 3'd2, 1'b0, zero_word});
        directed.push_back('{OP_NOP, 3'd5, 3'd2, 3'd1, 1'b0, zero_word});
        foreach (directed[i])
            send_word(directed[i].op, directed[i].r, directed[i].c, directed[i].rot,
                      directed[i].check_it, directed[i].want);

        // random part: mostly whole tours of random steps with reads mixed in
        for (int n = 0; n < 740; n++)
        begin
            if (n == 200)
            begin
                // long receiver hold while the sender keeps pushing
                fork
                    begin
                        hold_pop = 1'b1;
                        repeat (2000) @(posedge clk);
                        hold_pop = 1'b0;
                    end
                join_none
            end
            if (n == 400)
                drain_all();
            pick = $urandom_range(0, 99);
            rr = 3'($urandom_range(0, 7));
            cc = 3'($urandom_range(0, 7));
            if (pick < 4 || visit_count == FULL_TOUR && pick < 30)
                op = OP_START;
            else if (pick < 75)
                op = OP_STEP;
            else if (pick < 97)
                op = OP_READ;
            else
                op = OP_NOP;
            send_word(op, rr, cc, 3'($urandom_range(0, 7)), 1'b0, zero_word);
        end

        drain_all();
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
